>>> rtl/vps_pkg.sv
// ----------------------------------------------------------------------------
// vps_pkg
// Shared constants, register codes and types for the Verlet particle step.
// ----------------------------------------------------------------------------
package vps_pkg;

	// Default number format of positions and forces
	localparam int FRAC_BITS = 16;
	localparam int POS_WIDTH = 32;

	// Configuration register widths
	localparam int CFG_W     = 31;
	localparam int DAMP_W    = 18;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 2;

	// Fraction bits of the damping factor (unsigned Q2.16)
	localparam int DAMP_FRAC = 16;

	// Product magnitudes are held at 2^62, so 63 bits carry them
	localparam int LIM_W = 63;
	// Signed width of every sum before saturation
	localparam int SUM_W = 65;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HALF_EXTENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd3;

	// Boundary modes; the unused code behaves as none
	localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WRAP  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLAMP = 2'd2;

	// Reset values
	localparam logic [CFG_W-1:0]  HALF_EXTENT_RST = 31'd65536;
	localparam logic [CFG_W-1:0]  TIME_STEP_RST   = 31'd1092;
	localparam logic [DAMP_W-1:0] DAMPING_RST     = 18'd65536;

	typedef struct packed {
		logic [CFG_W-1:0]  half_extent;
		logic [CFG_W-1:0]  time_step;
		logic [DAMP_W-1:0] damping_factor;
		logic [MODE_W-1:0] boundary_mode;
	} cfg_t;

	// Load enables of the two multiplier stages
	typedef struct packed {
		logic ld_a;
		logic ld_b;
	} mul_ctl_t;

endpackage

>>> rtl/vps_cfg.sv
// ----------------------------------------------------------------------------
// vps_cfg
// Configuration register file: decodes writes and holds the four registers.
// ----------------------------------------------------------------------------
module vps_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            we,
	input  logic [vps_pkg::CFG_IDX_W-1:0]   index,
	input  logic [vps_pkg::CFG_W-1:0]       data,
	output vps_pkg::cfg_t                   cfg
);

	logic [vps_pkg::CFG_W-1:0]  half_extent_q;
	logic [vps_pkg::CFG_W-1:0]  time_step_q;
	logic [vps_pkg::DAMP_W-1:0] damping_q;
	logic [vps_pkg::MODE_W-1:0] mode_q;

	// Decode the register index and store the write data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_extent_q <= vps_pkg::HALF_EXTENT_RST;
			time_step_q   <= vps_pkg::TIME_STEP_RST;
			damping_q     <= vps_pkg::DAMPING_RST;
			mode_q        <= vps_pkg::MODE_NONE;
		end else if (we) begin
			unique case (index)
				vps_pkg::REG_HALF_EXTENT: half_extent_q <= data;
				vps_pkg::REG_TIME_STEP:   time_step_q   <= data;
				vps_pkg::REG_DAMPING:     damping_q     <= data[vps_pkg::DAMP_W-1:0];
				vps_pkg::REG_MODE:        mode_q        <= data[vps_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.half_extent    = half_extent_q;
	assign cfg.time_step      = time_step_q;
	assign cfg.damping_factor = damping_q;
	assign cfg.boundary_mode  = mode_q;

endmodule

>>> rtl/vps_mul.sv
// ----------------------------------------------------------------------------
// vps_mul
// Two-stage magnitude multiplier: split partial products, then combine,
// round half away from zero, shift and hold the magnitude at 2^62.
// ----------------------------------------------------------------------------
module vps_mul #(
	parameter int A_W = 32,
	parameter int B_W = 31,
	parameter int SH  = 16
) (
	input  logic                        clk,
	input  vps_pkg::mul_ctl_t           ctl,
	input  logic [A_W-1:0]              a_mag,
	input  logic                        a_neg,
	input  logic [B_W-1:0]              b,
	output logic [vps_pkg::LIM_W-1:0]   mag_s2,
	output logic                        neg_s2
);

	localparam int LO_W   = (A_W + 1) / 2;
	localparam int HI_W   = A_W - LO_W;
	localparam int PLO_W  = LO_W + B_W;
	localparam int PHI_W  = HI_W + B_W;
	localparam int FULL_W = A_W + B_W + 1;
	localparam int SHR_W  = FULL_W - SH;
	localparam int CMP_W  = (SHR_W > vps_pkg::LIM_W) ? SHR_W : vps_pkg::LIM_W;

	localparam logic [FULL_W-1:0] RND   = (FULL_W'(1) << SH) >> 1;
	localparam logic [CMP_W-1:0]  LIMIT = CMP_W'(1) << (vps_pkg::LIM_W - 1);

	logic [PLO_W-1:0]          plo_s1;
	logic [PHI_W-1:0]          phi_s1;
	logic                      neg_s1;
	logic [FULL_W-1:0]         full;
	logic [SHR_W-1:0]          shr;
	logic [CMP_W-1:0]          cmp;
	logic [vps_pkg::LIM_W-1:0] mag_c;

	// Form the low and high partial products
	always_ff @(posedge clk) begin
		if (ctl.ld_a) begin
			plo_s1 <= PLO_W'(a_mag[LO_W-1:0]) * PLO_W'(b);
			phi_s1 <= PHI_W'(a_mag[A_W-1:LO_W]) * PHI_W'(b);
			neg_s1 <= a_neg;
		end
	end

	// Combine, round, drop the fraction and hold at the limit
	always_comb begin
		full  = (FULL_W'(phi_s1) << LO_W) + FULL_W'(plo_s1) + RND;
		shr   = full[FULL_W-1:SH];
		cmp   = CMP_W'(shr);
		mag_c = (cmp > LIMIT) ? vps_pkg::LIM_W'(LIMIT) : vps_pkg::LIM_W'(cmp);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_b) begin
			mag_s2 <= mag_c;
			neg_s2 <= neg_s1;
		end
	end

endmodule

>>> rtl/verlet_particle_step_with_bounds.sv
// ----------------------------------------------------------------------------
// verlet_particle_step_with_bounds
// One position-Verlet step for a 2D particle, in signed fixed point, with an
// optional wrap or clamp boundary. The block accepts one particle per clock
// cycle while in_stall is low and returns its result through seven register
// stages: two for the force times time step product (split multiplier), one
// for the sum and saturation, one for the boundary test, two for the delta
// times damping product and one for the new previous position. Output stall
// holds only the stages that are full; empty stages keep taking transactions.
// Configuration registers are written through a plain write port and must
// only change while no particle is in flight.
// ----------------------------------------------------------------------------
module verlet_particle_step_with_bounds #(
	parameter int FRAC_BITS = vps_pkg::FRAC_BITS,
	parameter int POS_WIDTH = vps_pkg::POS_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [vps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vps_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [POS_WIDTH-1:0]    pos_x,
	input  logic signed [POS_WIDTH-1:0]    pos_y,
	input  logic signed [POS_WIDTH-1:0]    prev_x,
	input  logic signed [POS_WIDTH-1:0]    prev_y,
	input  logic signed [POS_WIDTH-1:0]    force_x,
	input  logic signed [POS_WIDTH-1:0]    force_y,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [POS_WIDTH-1:0]    next_x,
	output logic signed [POS_WIDTH-1:0]    next_y,
	output logic signed [POS_WIDTH-1:0]    next_prev_x,
	output logic signed [POS_WIDTH-1:0]    next_prev_y,
	output logic                           edge_hit,
	output logic                           saturated
);

	localparam int P      = POS_WIDTH;
	localparam int BASE_W = P + 2;
	localparam int SUM_W  = vps_pkg::SUM_W;
	localparam int LIM_W  = vps_pkg::LIM_W;
	localparam int CMP_W  = (vps_pkg::CFG_W > P) ? vps_pkg::CFG_W : P;

	localparam logic [P-1:0]            POS_MAX = {1'b0, {(P-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_HI  = signed'(SUM_W'(POS_MAX));
	localparam logic signed [SUM_W-1:0] SAT_LO  = ~SAT_HI;

	function automatic logic signed [P-1:0] sat_val(input logic signed [SUM_W-1:0] v);
		if (v > SAT_HI)
			return signed'(POS_MAX);
		else if (v < SAT_LO)
			return signed'(~POS_MAX);
		else
			return signed'(v[P-1:0]);
	endfunction

	function automatic logic sat_ovf(input logic signed [SUM_W-1:0] v);
		return (v > SAT_HI) || (v < SAT_LO);
	endfunction

	vps_pkg::cfg_t cfg;

	// Stage handshake
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

	// Axis lanes
	logic signed [P-1:0]      in_pos   [0:1];
	logic signed [P-1:0]      in_prev  [0:1];
	logic signed [P-1:0]      in_force [0:1];
	logic signed [P-1:0]      pos_s1   [0:1];
	logic signed [P-1:0]      pos_s2   [0:1];
	logic signed [P-1:0]      pos_s3   [0:1];
	logic signed [P-1:0]      pos_s4   [0:1];
	logic signed [P-1:0]      pos_s5   [0:1];
	logic signed [P-1:0]      pos_s6   [0:1];
	logic signed [BASE_W-1:0] base_s1  [0:1];
	logic signed [BASE_W-1:0] base_s2  [0:1];
	logic [LIM_W-1:0]         fmag_s2  [0:1];
	logic                     fneg_s2  [0:1];
	logic signed [P-1:0]      nxt_s3   [0:1];
	logic signed [P-1:0]      nxt_s4   [0:1];
	logic signed [P-1:0]      nxt_s5   [0:1];
	logic signed [P-1:0]      nxt_s6   [0:1];
	logic signed [P-1:0]      nxt_s7   [0:1];
	logic [P:0]               dmag_s4  [0:1];
	logic [P:0]               dmag_s5  [0:1];
	logic [P:0]               dmag_s6  [0:1];
	logic                     dneg_s4  [0:1];
	logic                     dneg_s5  [0:1];
	logic                     dneg_s6  [0:1];
	logic [LIM_W-1:0]         pmag_s6  [0:1];
	logic                     pneg_s6  [0:1];
	logic signed [P-1:0]      nprev_s7 [0:1];
	logic                     ovf3     [0:1];
	logic                     hit_ax   [0:1];
	logic                     ovf7     [0:1];

	// Per-item flags
	logic satf_s3, satf_s4, satf_s5, satf_s6, satf_s7;
	logic hit_s4, hit_s5, hit_s6, hit_s7;
	logic wrap_s4, wrap_s5, wrap_s6;

	// Boundary set-up
	logic                wrap, clamp;
	logic [P-1:0]        size;
	logic signed [P-1:0] size_s, nsize_s;

	vps_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	assign in_pos[0]   = pos_x;
	assign in_pos[1]   = pos_y;
	assign in_prev[0]  = prev_x;
	assign in_prev[1]  = prev_y;
	assign in_force[0] = force_x;
	assign in_force[1] = force_y;

	// Take the extent down to the largest position value
	always_comb begin
		size    = (CMP_W'(cfg.half_extent) > CMP_W'(POS_MAX)) ? POS_MAX
			: P'(cfg.half_extent);
		size_s  = signed'(size);
		nsize_s = -size_s;
		wrap    = cfg.boundary_mode == vps_pkg::MODE_WRAP;
		clamp   = cfg.boundary_mode == vps_pkg::MODE_CLAMP;
	end

	// A stage advances when it is empty or the next one advances
	assign rdy7     = !valid_s7 || !out_stall;
	assign rdy6     = !valid_s6 || rdy7;
	assign rdy5     = !valid_s5 || rdy6;
	assign rdy4     = !valid_s4 || rdy5;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
			if (rdy6) valid_s6 <= valid_s5;
			if (rdy7) valid_s7 <= valid_s6;
		end
	end

	for (genvar a = 0; a < 2; a++) begin : g_axis
		logic [P-1:0]              fmag;
		logic signed [SUM_W-1:0]   base_e, fmag_e, sum3;
		logic [P:0]                delta, dmag;
		logic                      over, under;
		logic signed [P-1:0]       bounded;
		logic [SUM_W-1:0]          op7;
		logic                      sub7;
		logic signed [SUM_W-1:0]   nxt_e, sum7;

		// Stage 1: form 2*pos - prev and the force magnitude
		assign fmag = in_force[a][P-1] ? (~in_force[a] + 1'b1) : in_force[a];

		always_ff @(posedge clk) begin
			if (rdy1) begin
				pos_s1[a]  <= in_pos[a];
				base_s1[a] <= signed'({in_pos[a][P-1], in_pos[a], 1'b0}
					- {{2{in_prev[a][P-1]}}, in_prev[a]});
			end
		end

		vps_mul #(
			.A_W (P),
			.B_W (vps_pkg::CFG_W),
			.SH  (FRAC_BITS)
		) u_force_mul (
			.clk    (clk),
			.ctl    (vps_pkg::mul_ctl_t'{ld_a: rdy1, ld_b: rdy2}),
			.a_mag  (fmag),
			.a_neg  (in_force[a][P-1]),
			.b      (cfg.time_step),
			.mag_s2 (fmag_s2[a]),
			.neg_s2 (fneg_s2[a])
		);

		// Stage 2: carry the base while the product completes
		always_ff @(posedge clk) begin
			if (rdy2) begin
				pos_s2[a]  <= pos_s1[a];
				base_s2[a] <= base_s1[a];
			end
		end

		// Stage 3: add the force term and saturate
		always_comb begin
			base_e = SUM_W'(base_s2[a]);
			fmag_e = signed'(SUM_W'(fmag_s2[a]));
			sum3   = fneg_s2[a] ? base_e - fmag_e : base_e + fmag_e;
		end
		assign ovf3[a] = sat_ovf(sum3);

		always_ff @(posedge clk) begin
			if (rdy3) begin
				pos_s3[a] <= pos_s2[a];
				nxt_s3[a] <= sat_val(sum3);
			end
		end

		// Stage 4: take the delta and apply the boundary
		always_comb begin
			delta   = {nxt_s3[a][P-1], nxt_s3[a]} - {pos_s3[a][P-1], pos_s3[a]};
			dmag    = delta[P] ? (~delta + 1'b1) : delta;
			over    = nxt_s3[a] > size_s;
			under   = nxt_s3[a] < nsize_s;
			hit_ax[a] = (wrap || clamp) && (over || under);
			if (!(wrap || clamp))
				bounded = nxt_s3[a];
			else if (over)
				bounded = wrap ? nsize_s : size_s;
			else if (under)
				bounded = wrap ? size_s : nsize_s;
			else
				bounded = nxt_s3[a];
		end

		always_ff @(posedge clk) begin
			if (rdy4) begin
				pos_s4[a]  <= pos_s3[a];
				nxt_s4[a]  <= bounded;
				dmag_s4[a] <= dmag;
				dneg_s4[a] <= delta[P];
			end
		end

		// Stages 5 and 6: delta times damping
		vps_mul #(
			.A_W (P + 1),
			.B_W (vps_pkg::DAMP_W),
			.SH  (vps_pkg::DAMP_FRAC)
		) u_damp_mul (
			.clk    (clk),
			.ctl    (vps_pkg::mul_ctl_t'{ld_a: rdy5, ld_b: rdy6}),
			.a_mag  (dmag_s4[a]),
			.a_neg  (dneg_s4[a]),
			.b      (cfg.damping_factor),
			.mag_s2 (pmag_s6[a]),
			.neg_s2 (pneg_s6[a])
		);

		always_ff @(posedge clk) begin
			if (rdy5) begin
				pos_s5[a]  <= pos_s4[a];
				nxt_s5[a]  <= nxt_s4[a];
				dmag_s5[a] <= dmag_s4[a];
				dneg_s5[a] <= dneg_s4[a];
			end
			if (rdy6) begin
				pos_s6[a]  <= pos_s5[a];
				nxt_s6[a]  <= nxt_s5[a];
				dmag_s6[a] <= dmag_s5[a];
				dneg_s6[a] <= dneg_s5[a];
			end
		end

		// Stage 7: new previous position (wrap: next - delta, clamp: next + damped)
		always_comb begin
			op7   = wrap_s6 ? SUM_W'(dmag_s6[a]) : SUM_W'(pmag_s6[a]);
			sub7  = wrap_s6 ? !dneg_s6[a] : pneg_s6[a];
			nxt_e = SUM_W'(nxt_s6[a]);
			sum7  = sub7 ? nxt_e - signed'(op7) : nxt_e + signed'(op7);
		end
		assign ovf7[a] = hit_s6 && sat_ovf(sum7);

		always_ff @(posedge clk) begin
			if (rdy7) begin
				nxt_s7[a]   <= nxt_s6[a];
				nprev_s7[a] <= hit_s6 ? sat_val(sum7) : pos_s6[a];
			end
		end
	end

	// Per-item flags travel with the lanes
	always_ff @(posedge clk) begin
		if (rdy3) satf_s3 <= ovf3[0] || ovf3[1];
		if (rdy4) begin
			satf_s4 <= satf_s3;
			hit_s4  <= hit_ax[0] || hit_ax[1];
			wrap_s4 <= wrap;
		end
		if (rdy5) begin
			satf_s5 <= satf_s4;
			hit_s5  <= hit_s4;
			wrap_s5 <= wrap_s4;
		end
		if (rdy6) begin
			satf_s6 <= satf_s5;
			hit_s6  <= hit_s5;
			wrap_s6 <= wrap_s5;
		end
		if (rdy7) begin
			satf_s7 <= satf_s6 || ovf7[0] || ovf7[1];
			hit_s7  <= hit_s6;
		end
	end

	assign out_valid   = valid_s7;
	assign next_x      = nxt_s7[0];
	assign next_y      = nxt_s7[1];
	assign next_prev_x = nprev_s7[0];
	assign next_prev_y = nprev_s7[1];
	assign edge_hit    = hit_s7;
	assign saturated   = satf_s7;

`ifndef NO_ASSERTIONS
	// Input is held back only by an item sitting in the first stage
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with first stage empty");

	// A result appears only from an item held in the stage before
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s7) |-> $past(valid_s6))
		else $error("result appeared without a preceding item");

	// A blocked stage keeps its item and its payload
	a_stage6_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s6 && !rdy7) |=> (valid_s6 && $stable(nxt_s6[0]) && $stable(nxt_s6[1])))
		else $error("stage 6 lost its item under back-pressure");
`endif

endmodule
